FILE: rtl/rlt_pkg.sv
// rlt_pkg: shared widths, operation codes, microcode word layout and the
// control program of the reversible list table. No dependencies.
package rlt_pkg;

  localparam int NAME_W        = 10;
  localparam int OP_W          = 2;
  localparam int NAME_MAX      = 2 ** NAME_W - 1;
  localparam int ITEMS_DEFAULT = 1023;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 32;
  localparam int PC_W          = 5;

  typedef enum logic [OP_W-1:0] {
    OP_POP  = 2'd0,
    OP_JOIN = 2'd1,
    OP_REV  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // program step addresses
  localparam logic [PC_W-1:0] S_POP_RD   = 5'd0;
  localparam logic [PC_W-1:0] S_POP_HEAD = 5'd1;
  localparam logic [PC_W-1:0] S_POP_LINK = 5'd2;
  localparam logic [PC_W-1:0] S_POP_RDNH = 5'd3;
  localparam logic [PC_W-1:0] S_POP_FIX  = 5'd4;
  localparam logic [PC_W-1:0] S_POP_FREE = 5'd5;
  localparam logic [PC_W-1:0] S_REV_RD   = 5'd6;
  localparam logic [PC_W-1:0] S_REV_HEAD = 5'd7;
  localparam logic [PC_W-1:0] S_REV_FLIP = 5'd8;
  localparam logic [PC_W-1:0] S_JN_RD    = 5'd9;
  localparam logic [PC_W-1:0] S_JN_HA    = 5'd10;
  localparam logic [PC_W-1:0] S_JN_HB    = 5'd11;
  localparam logic [PC_W-1:0] S_JN_FIXA  = 5'd12;
  localparam logic [PC_W-1:0] S_JN_RDHB  = 5'd13;
  localparam logic [PC_W-1:0] S_JN_FIXB  = 5'd14;
  localparam logic [PC_W-1:0] S_FIN      = 5'd15;
  localparam logic [PC_W-1:0] S_HEAD     = 5'd16;
  localparam logic [PC_W-1:0] S_DONE     = 5'd17;

  typedef enum logic [2:0] {RD_A, RD_B, RD_X, RD_Y, RD_R1, RD_RES} rd_sel_t;
  typedef enum logic [1:0] {WA_A, WA_B, WA_X, WA_Y} wa_sel_t;
  typedef enum logic [1:0] {WR_OFF, WR_ON, WR_EQ, WR_NE} wr_mode_t;
  typedef enum logic [2:0] {WD_R1, WD_PICK, WD_A, WD_B, WD_X} wd_sel_t;
  typedef enum logic {CL_R1, CL_R2} cmp_l_t;
  typedef enum logic [1:0] {CR_A, CR_B, CR_X} cmp_r_t;
  typedef enum logic [1:0] {Y_HOLD, Y_R1, Y_NH} y_sel_t;
  typedef enum logic [1:0] {NX_NEXT, NX_GOTO, NX_JEQ, NX_DONE} nx_t;

  typedef struct packed {
    rd_sel_t          rd;
    cmp_l_t           cl;
    cmp_r_t           cr;
    wa_sel_t          wa;
    wr_mode_t         w1;
    wd_sel_t          d1;
    wr_mode_t         w2;
    wd_sel_t          d2;
    logic             x_ld;
    y_sel_t           y_ld;
    logic             res_ld;
    logic             rem_ld;
    logic             head_ld;
    nx_t              nx;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic cmp;
    logic out_free;
  } seq_stat_t;

  function automatic logic wr_en(input wr_mode_t m, input logic c);
    logic e;
    case (m)
      WR_ON:   e = 1'b1;
      WR_EQ:   e = c;
      WR_NE:   e = !c;
      default: e = 1'b0;
    endcase
    return e;
  endfunction

  // control program, one word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = ucode_t'('0);
    case (pc)
      S_POP_RD: begin
        w.rd = RD_A;
      end
      S_POP_HEAD: begin
        w.x_ld = 1'b1; w.rd = RD_R1;
        w.cl = CL_R1; w.cr = CR_A; w.nx = NX_JEQ; w.target = S_FIN;
      end
      S_POP_LINK: begin
        // tail takes the head's other neighbour as its new head
        w.cl = CL_R2; w.cr = CR_A;
        w.wa = WA_A; w.w1 = WR_ON; w.d1 = WD_PICK; w.y_ld = Y_NH;
      end
      S_POP_RDNH: begin
        w.rd = RD_Y;
      end
      S_POP_FIX: begin
        w.cl = CL_R1; w.cr = CR_X; w.wa = WA_Y;
        w.w1 = WR_EQ; w.d1 = WD_A; w.w2 = WR_NE; w.d2 = WD_A;
      end
      S_POP_FREE: begin
        w.wa = WA_X; w.w1 = WR_ON; w.d1 = WD_X; w.w2 = WR_ON; w.d2 = WD_X;
        w.rem_ld = 1'b1; w.nx = NX_GOTO; w.target = S_FIN;
      end
      S_REV_RD: begin
        w.rd = RD_A;
      end
      S_REV_HEAD: begin
        w.x_ld = 1'b1; w.rd = RD_R1;
        w.cl = CL_R1; w.cr = CR_A; w.nx = NX_JEQ; w.target = S_FIN;
      end
      S_REV_FLIP: begin
        w.cl = CL_R2; w.cr = CR_A; w.wa = WA_X;
        w.w2 = WR_EQ; w.d2 = WD_R1; w.w1 = WR_ON; w.d1 = WD_A;
        w.res_ld = 1'b1; w.nx = NX_GOTO; w.target = S_FIN;
      end
      S_JN_RD: begin
        w.rd = RD_A;
      end
      S_JN_HA: begin
        // read of b sees the old link, the write lands after it
        w.x_ld = 1'b1; w.rd = RD_B; w.wa = WA_B; w.w1 = WR_ON; w.d1 = WD_R1;
      end
      S_JN_HB: begin
        w.y_ld = Y_R1; w.rd = RD_X; w.wa = WA_A; w.w1 = WR_ON; w.d1 = WD_R1;
      end
      S_JN_FIXA: begin
        w.cl = CL_R2; w.cr = CR_A; w.wa = WA_X;
        w.w2 = WR_EQ; w.d2 = WD_B; w.w1 = WR_NE; w.d1 = WD_B;
      end
      S_JN_RDHB: begin
        w.rd = RD_Y;
      end
      S_JN_FIXB: begin
        w.cl = CL_R2; w.cr = CR_B; w.wa = WA_Y;
        w.w2 = WR_EQ; w.d2 = WD_A; w.w1 = WR_NE; w.d1 = WD_A;
      end
      S_FIN: begin
        w.rd = RD_RES;
      end
      S_HEAD: begin
        w.head_ld = 1'b1;
      end
      S_DONE: begin
        w.nx = NX_DONE;
      end
      default: begin
        w.nx = NX_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/reversible_list_table.sv
// reversible_list_table: top level with stream ports and the output register.
// Depends on rlt_pkg, rlt_sequencer and rlt_datapath (rlt_ram below it).
//
//   channel   dir  tdata (low bit up)                                 tuser
//   s_axis    in   first_list[9:0] second_list[19:10] zero[23:20]     opcode[1:0]
//   m_axis    out  result_list[9:0] result_head[19:10]                error[0]
//                  removed_item[29:20] zero[31:30]
//
// one request at a time; an error, a no-op or an empty list goes straight to the
// last step, and other requests step through their part of the control program
// with one link-memory access per port per step.
// after reset a sweep writes every table entry, min(ITEMS,1023)+1 of them
// (1024 by default), before s_axis_tready rises.
// a result waits in the output register; the next request is taken meanwhile
// and its last step holds until m_axis takes the previous result.
module reversible_list_table #(
  parameter int ITEMS = rlt_pkg::ITEMS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rlt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // first_list, second_list
  input  logic [rlt_pkg::OP_W-1:0]        s_axis_tuser,   // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rlt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // result_list, result_head,
                                                          // removed_item
  output logic [0:0]                     m_axis_tuser    // error
);
  import rlt_pkg::*;

  logic              accept, busy, clearing, cmp, emit;
  logic [PC_W-1:0]   entry_pc;
  ucode_t            ctl;
  seq_stat_t         stat;
  logic [NAME_W-1:0] result_list, result_head, removed_item;
  logic              error;

  assign s_axis_tready = !busy && !clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign stat.cmp      = cmp;
  assign stat.out_free = !m_axis_tvalid || m_axis_tready;
  assign emit          = busy && (ctl.nx == NX_DONE) && stat.out_free;

  rlt_sequencer u_seq (
    .clk(clk), .rst(rst), .start(accept), .entry_pc(entry_pc),
    .stat(stat), .ctl(ctl), .busy(busy)
  );

  rlt_datapath #(.ITEMS(ITEMS)) u_dp (
    .clk(clk), .rst(rst), .accept(accept),
    .opcode(s_axis_tuser),
    .first_list(s_axis_tdata[NAME_W-1:0]),
    .second_list(s_axis_tdata[2*NAME_W-1:NAME_W]),
    .ctl(ctl), .cmp(cmp), .clearing(clearing), .entry_pc(entry_pc),
    .result_list(result_list), .result_head(result_head),
    .removed_item(removed_item), .error(error)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {(OUT_TDATA_W - 3 * NAME_W)'(0), removed_item, result_head,
                       result_list};
      m_axis_tuser <= error;
    end
  end

endmodule

FILE: rtl/rlt_ram.sv
// rlt_ram: simple dual-port memory, one write and one registered read port.
// Read returns the old word on a same-address write. No dependencies.
module rlt_ram #(
  parameter int DEPTH = 1024,
  parameter int W     = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [W-1:0]             wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [W-1:0]             rd
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

FILE: rtl/rlt_datapath.sv
// rlt_datapath: link memories, working registers, address and data selection,
// request decode and the clearing sweep. Depends on rlt_pkg and rlt_ram.
module rlt_datapath #(
  parameter int ITEMS = rlt_pkg::ITEMS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [rlt_pkg::OP_W-1:0]   opcode,
  input  logic [rlt_pkg::NAME_W-1:0] first_list,
  input  logic [rlt_pkg::NAME_W-1:0] second_list,
  input  rlt_pkg::ucode_t            ctl,
  output logic                      cmp,
  output logic                      clearing,
  output logic [rlt_pkg::PC_W-1:0]   entry_pc,
  output logic [rlt_pkg::NAME_W-1:0] result_list,
  output logic [rlt_pkg::NAME_W-1:0] result_head,
  output logic [rlt_pkg::NAME_W-1:0] removed_item,
  output logic                      error
);
  import rlt_pkg::*;

  localparam int DEPTH = ((ITEMS < NAME_MAX) ? ITEMS : NAME_MAX) + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [AW-1:0] ra, rb, x, y, res, head, rem;
  logic          err;
  logic [AW-1:0] r1, r2;
  logic [AW-1:0] rd_addr, wa, wd1, wd2, lhs, rhs, nh, pick;
  logic          we1, we2;
  logic [AW-1:0] clr_cnt;

  logic          a_bad, b_bad, a_zero, b_zero;
  logic [AW-1:0] a_n, b_n, res_next;
  logic          err_next;

  rlt_ram #(.DEPTH(DEPTH), .W(AW)) u_link_one (
    .clk(clk), .we(we1), .wa(wa), .wd(wd1), .ra(rd_addr), .rd(r1)
  );

  rlt_ram #(.DEPTH(DEPTH), .W(AW)) u_link_two (
    .clk(clk), .we(we2), .wa(wa), .wd(wd2), .ra(rd_addr), .rd(r2)
  );

  // request decode
  always_comb begin
    a_bad    = 32'(first_list) > ITEMS;
    b_bad    = (opcode == OP_JOIN) && (32'(second_list) > ITEMS);
    a_zero   = first_list == '0;
    b_zero   = second_list == '0;
    a_n      = first_list[AW-1:0];
    b_n      = second_list[AW-1:0];
    err_next = 1'b0;
    res_next = '0;
    entry_pc = S_DONE;
    if (a_bad || b_bad) begin
      err_next = 1'b1;
    end else begin
      case (opcode)
        OP_POP: begin
          if (!a_zero) begin
            res_next = a_n;
            entry_pc = S_POP_RD;
          end
        end
        OP_JOIN: begin
          if (a_zero) begin
            res_next = b_n;
            entry_pc = b_zero ? S_DONE : S_FIN;
          end else if (b_zero || (first_list == second_list)) begin
            res_next = a_n;
            entry_pc = S_FIN;
          end else begin
            res_next = b_n;
            entry_pc = S_JN_RD;
          end
        end
        OP_REV: begin
          if (!a_zero) begin
            res_next = a_n;
            entry_pc = S_REV_RD;
          end
        end
        default: begin
          res_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    case (ctl.rd)
      RD_A:    rd_addr = ra;
      RD_B:    rd_addr = rb;
      RD_X:    rd_addr = x;
      RD_Y:    rd_addr = y;
      RD_R1:   rd_addr = r1;
      RD_RES:  rd_addr = res;
      default: rd_addr = ra;
    endcase
    lhs = (ctl.cl == CL_R2) ? r2 : r1;
    case (ctl.cr)
      CR_A:    rhs = ra;
      CR_B:    rhs = rb;
      CR_X:    rhs = x;
      default: rhs = ra;
    endcase
    cmp  = lhs == rhs;
    nh   = (r1 == ra) ? r2 : r1;
    pick = cmp ? r1 : r2;
  end

  function automatic logic [AW-1:0] wdata(input wd_sel_t s, input logic [AW-1:0] v_r1,
      input logic [AW-1:0] v_pick, input logic [AW-1:0] v_a, input logic [AW-1:0] v_b,
      input logic [AW-1:0] v_x);
    logic [AW-1:0] d;
    case (s)
      WD_R1:   d = v_r1;
      WD_PICK: d = v_pick;
      WD_A:    d = v_a;
      WD_B:    d = v_b;
      WD_X:    d = v_x;
      default: d = v_r1;
    endcase
    return d;
  endfunction

  // the sweep after reset owns both write ports
  always_comb begin
    if (clearing) begin
      wa  = clr_cnt;
      wd1 = clr_cnt;
      wd2 = clr_cnt;
      we1 = 1'b1;
      we2 = 1'b1;
    end else begin
      case (ctl.wa)
        WA_A:    wa = ra;
        WA_B:    wa = rb;
        WA_X:    wa = x;
        WA_Y:    wa = y;
        default: wa = ra;
      endcase
      wd1 = wdata(ctl.d1, r1, pick, ra, rb, x);
      wd2 = wdata(ctl.d2, r1, pick, ra, rb, x);
      we1 = wr_en(ctl.w1, cmp);
      we2 = wr_en(ctl.w2, cmp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (clr_cnt == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ra   <= a_n;
      rb   <= b_n;
      res  <= res_next;
      err  <= err_next;
      head <= '0;
      rem  <= '0;
    end else begin
      if (ctl.x_ld) begin
        x <= r1;
      end
      case (ctl.y_ld)
        Y_R1:    y <= r1;
        Y_NH:    y <= nh;
        default: y <= y;
      endcase
      if (ctl.res_ld) begin
        res <= x;
      end
      if (ctl.rem_ld) begin
        rem <= x;
      end
      if (ctl.head_ld) begin
        head <= r1;
      end
    end
  end

  assign result_list  = NAME_W'(res);
  assign result_head  = NAME_W'(head);
  assign removed_item = NAME_W'(rem);
  assign error        = err;

endmodule

FILE: rtl/rlt_sequencer.sv
// rlt_sequencer: step counter and conditional jumps over the control program
// held in rlt_pkg. Depends on rlt_pkg.
module rlt_sequencer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [rlt_pkg::PC_W-1:0] entry_pc,
  input  rlt_pkg::seq_stat_t       stat,
  output rlt_pkg::ucode_t          ctl,
  output logic                    busy
);
  import rlt_pkg::*;

  logic [PC_W-1:0] pc, pc_next;
  logic            busy_next;
  ucode_t          word;

  assign word = ucode_rom(pc);
  assign ctl  = busy ? word : ucode_t'('0);

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = entry_pc;
      busy_next = 1'b1;
    end else if (busy) begin
      case (word.nx)
        NX_NEXT: pc_next = pc + PC_W'(1);
        NX_GOTO: pc_next = word.target;
        NX_JEQ:  pc_next = stat.cmp ? word.target : pc + PC_W'(1);
        NX_DONE: begin
          // hold on the last step until the output register frees up
          if (stat.out_free) begin
            busy_next = 1'b0;
          end
        end
        default: pc_next = pc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= S_DONE;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule
